// ===== design/vkhs_pkg.sv =====
// Shared types and constants for the variable-kappa heat stencil block.
// No dependencies.
`timescale 1ns / 1ps

package vkhs_pkg;

  localparam int VAL_W       = 32;
  localparam int FLUX_STAGES = 6;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_AW     = 4;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DEPTH  = 2'd2,
    REG_FACTOR = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic       last;
    logic [9:0] plane;
    logic [5:0] row;
    logic [5:0] col;
  } meta_t;

  // one interior point: centre, source and the six face neighbors
  typedef struct packed {
    logic [5:0][VAL_W-1:0] un;
    logic [5:0][VAL_W-1:0] kn;
    logic [VAL_W-1:0]      uc;
    logic [VAL_W-1:0]      kc;
    logic [VAL_W-1:0]      src;
    meta_t                 meta;
  } op_t;

  typedef struct packed {
    meta_t            meta;
    logic [VAL_W-1:0] value;
  } res_t;

endpackage

// ===== design/variable_kappa_heat_stencil_3d.sv =====
// One item per cycle sustained; a result is formed when the point that follows,
// in raster order, the point one plane above its centre point is transferred,
// and then passes the read, operand and arithmetic registers and the queue.
// Input flow is gated by a 16-entry result queue and pipeline occupancy.
// Synchronous reset clears position counters, pipeline valids and the queue,
// and sets the registers to their defaults; the plane stores are not cleared.
`timescale 1ns / 1ps

module variable_kappa_heat_stencil_3d import vkhs_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 1024,
  parameter int FRAC_BITS  = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // old_value, source_term, conductivity
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // new_value, col, row, plane, zero pad
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic [6:0]  grid_width, grid_height;
  logic [10:0] grid_depth;
  logic [31:0] diffusion_factor;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [DW-1:0] d_eff;

  logic                   accept;
  logic [1:0]             win_busy;
  logic [FLUX_STAGES-1:0] flux_busy;
  logic [4:0]             inflight;
  logic [FIFO_AW:0]       count;
  logic                   op_valid, res_valid;
  op_t                    op;
  res_t                   res, out_res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= 7'd64;
      grid_height      <= 7'd64;
      grid_depth       <= 11'd64;
      diffusion_factor <= 32'd11787827;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_WIDTH:  grid_width       <= pwdata[6:0];
        REG_HEIGHT: grid_height      <= pwdata[6:0];
        REG_DEPTH:  grid_depth       <= pwdata[10:0];
        REG_FACTOR: diffusion_factor <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_WIDTH:  prdata = 32'(grid_width);
      REG_HEIGHT: prdata = 32'(grid_height);
      REG_DEPTH:  prdata = 32'(grid_depth);
      REG_FACTOR: prdata = diffusion_factor;
    endcase
  end

  always_comb begin
    if (grid_width < 7'd3) begin
      w_eff = WW'(3);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(grid_width);
    end
    if (grid_height < 7'd3) begin
      h_eff = HW'(3);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(grid_height);
    end
    if (grid_depth < 11'd3) begin
      d_eff = DW'(3);
    end else if (32'(grid_depth) > MAX_DEPTH) begin
      d_eff = DW'(MAX_DEPTH);
    end else begin
      d_eff = DW'(grid_depth);
    end
  end

  // each point in flight yields at most one result
  always_comb begin
    inflight = 5'(win_busy[0]) + 5'(win_busy[1]);
    for (int s = 0; s < FLUX_STAGES; s++) begin
      inflight = inflight + 5'(flux_busy[s]);
    end
  end

  assign s_tready = 6'(count) + 6'(inflight) < 6'(FIFO_DEPTH);
  assign accept   = s_tvalid && s_tready;

  vkhs_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_u     (s_tdata[31:0]),
    .in_s     (s_tdata[63:32]),
    .in_k     (s_tdata[95:64]),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .d_eff    (d_eff),
    .busy     (win_busy),
    .op_valid (op_valid),
    .op       (op)
  );

  vkhs_flux #(
    .FRAC_BITS (FRAC_BITS)
  ) u_flux (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (op_valid),
    .op        (op),
    .factor    (diffusion_factor),
    .busy      (flux_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  vkhs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_data  (res),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (out_res),
    .count    (count)
  );

  assign m_tdata = {2'b00, out_res.meta.plane, out_res.meta.row, out_res.meta.col,
                    out_res.value};
  assign m_tlast = out_res.meta.last;

endmodule

// ===== design/vkhs_window.sv =====
// Plane stores, raster position counters and neighbor taps.
// Depends on vkhs_pkg.
`timescale 1ns / 1ps

module vkhs_window import vkhs_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [VAL_W-1:0] in_u,
  input  logic [VAL_W-1:0] in_s,
  input  logic [VAL_W-1:0] in_k,
  input  logic [WW-1:0]    w_eff,
  input  logic [HW-1:0]    h_eff,
  input  logic [DW-1:0]    d_eff,
  output logic [1:0]       busy,
  output logic             op_valid,
  output op_t              op
);

  localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW2   = $clog2(2 * PLANE);
  localparam int IW    = $clog2(MAX_WIDTH);
  localparam int JW    = $clog2(MAX_HEIGHT);
  localparam int KW    = $clog2(MAX_DEPTH);

  logic [3*VAL_W-1:0] mem_a [2*PLANE];
  logic [2*VAL_W-1:0] mem_b [2*PLANE];

  logic [IW-1:0] pi;
  logic [JW-1:0] pj;
  logic [KW-1:0] pk;

  logic [31:0] addr, base_cur, base_prv;
  logic [31:0] ia1, ia2, ib1, ib2;

  logic [3*VAL_W-1:0] ra1;
  logic [2*VAL_W-1:0] ra2, rb1, rb2;

  logic             s1_valid;
  logic [VAL_W-1:0] s1_u, s1_k;
  logic [IW-1:0]    s1_i;
  logic [JW-1:0]    s1_j;
  logic [KW-1:0]    s1_kk;
  logic             s1_int, s1_last;

  logic               p_valid;
  logic [3*VAL_W-1:0] p_a1;
  logic [2*VAL_W-1:0] p_a2, p_b1, p_b2;
  logic [VAL_W-1:0]   p_u, p_k;
  logic [IW-1:0]      p_i;
  logic [JW-1:0]      p_j;
  logic [KW-1:0]      p_kk;
  logic               p_int, p_last;
  logic [VAL_W-1:0]   l_u, l_k;

  logic interior;
  op_t  op_next;

  always_comb begin
    addr     = 32'(pj) * MAX_WIDTH + 32'(pi);
    base_cur = pk[0] ? 32'(PLANE) : 32'd0;
    base_prv = pk[0] ? 32'd0 : 32'(PLANE);
    ia1      = base_prv + addr;
    ia2      = base_prv + addr + 32'(MAX_WIDTH);
    ib1      = base_prv + addr - 32'(MAX_WIDTH);
    ib2      = base_cur + addr;
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      mem_a[ib2[AW2-1:0]] <= {in_s, in_k, in_u};
      ra1 <= mem_a[ia1[AW2-1:0]];
      ra2 <= mem_a[ia2[AW2-1:0]][2*VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      mem_b[ib2[AW2-1:0]] <= {in_k, in_u};
      rb1 <= mem_b[ib1[AW2-1:0]];
      rb2 <= mem_b[ib2[AW2-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pi <= '0;
      pj <= '0;
      pk <= '0;
    end else if (in_valid) begin
      if (32'(pi) + 32'd1 >= 32'(w_eff)) begin
        pi <= '0;
        if (32'(pj) + 32'd1 >= 32'(h_eff)) begin
          pj <= '0;
          pk <= (32'(pk) + 32'd1 >= 32'(d_eff)) ? '0 : pk + KW'(1);
        end else begin
          pj <= pj + JW'(1);
        end
      end else begin
        pi <= pi + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_u  <= in_u;
      s1_k  <= in_k;
      s1_i  <= pi;
      s1_j  <= pj;
      s1_kk <= pk;
    end
  end

  // centre is the previous point; its right neighbor is the current read
  always_comb begin
    s1_int   = 32'(s1_kk) >= 32'd2 && 32'(s1_kk) <= 32'(d_eff) - 32'd1 &&
               32'(s1_i) >= 32'd1 && 32'(s1_i) <= 32'(w_eff) - 32'd2 &&
               32'(s1_j) >= 32'd1 && 32'(s1_j) <= 32'(h_eff) - 32'd2;
    s1_last  = 32'(s1_i) == 32'(w_eff) - 32'd2 &&
               32'(s1_j) == 32'(h_eff) - 32'd2 &&
               32'(s1_kk) - 32'd1 == 32'(d_eff) - 32'd2;
    interior = p_valid && p_int;
    op_next.uc     = p_a1[VAL_W-1:0];
    op_next.kc     = p_a1[2*VAL_W-1:VAL_W];
    op_next.src    = p_a1[3*VAL_W-1:2*VAL_W];
    op_next.un[0]  = ra1[VAL_W-1:0];
    op_next.kn[0]  = ra1[2*VAL_W-1:VAL_W];
    op_next.un[1]  = l_u;
    op_next.kn[1]  = l_k;
    op_next.un[2]  = p_a2[VAL_W-1:0];
    op_next.kn[2]  = p_a2[2*VAL_W-1:VAL_W];
    op_next.un[3]  = p_b1[VAL_W-1:0];
    op_next.kn[3]  = p_b1[2*VAL_W-1:VAL_W];
    op_next.un[4]  = p_u;
    op_next.kn[4]  = p_k;
    op_next.un[5]  = p_b2[VAL_W-1:0];
    op_next.kn[5]  = p_b2[2*VAL_W-1:VAL_W];
    op_next.meta.col   = 6'(p_i);
    op_next.meta.row   = 6'(p_j);
    op_next.meta.plane = 10'(p_kk - KW'(1));
    op_next.meta.last  = p_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      op_valid <= 1'b0;
    end else begin
      op_valid <= s1_valid && interior;
      if (s1_valid) begin
        p_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      op     <= op_next;
      l_u    <= p_a1[VAL_W-1:0];
      l_k    <= p_a1[2*VAL_W-1:VAL_W];
      p_a1   <= ra1;
      p_a2   <= ra2;
      p_b1   <= rb1;
      p_b2   <= rb2;
      p_u    <= s1_u;
      p_k    <= s1_k;
      p_i    <= s1_i;
      p_j    <= s1_j;
      p_kk   <= s1_kk;
      p_int  <= s1_int;
      p_last <= s1_last;
    end
  end

  assign busy = {op_valid, s1_valid};

endmodule

// ===== design/vkhs_flux.sv =====
// Arithmetic pipeline: face fluxes, factor scaling, source add, saturation.
// Depends on vkhs_pkg.
`timescale 1ns / 1ps

module vkhs_flux import vkhs_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  op_t                    op,
  input  logic [VAL_W-1:0]       factor,
  output logic [FLUX_STAGES-1:0] busy,
  output logic                   res_valid,
  output res_t                   res
);

  localparam int TW = 66 - FRAC_BITS;
  localparam int SW = TW + 3;
  localparam int SL = SW / 2;
  localparam int SH = SW - SL;
  localparam int FW = 32 + SW;
  localparam int CW = (FW > 36) ? FW : 36;
  localparam longint LIM = longint'(1) <<< 34;
  localparam logic signed [36:0] MAXV = 37'sd2147483647;
  localparam logic signed [36:0] MINV = -37'sd2147483648;

  logic [FLUX_STAGES-1:0] v;

  logic signed [32:0] ks1 [6];
  logic signed [32:0] ud1 [6];
  logic signed [32:0] us1;
  meta_t              m1;

  logic signed [65:0] prod2 [6];
  logic signed [32:0] us2;
  meta_t              m2;

  logic signed [SW-1:0] sum_next;
  logic signed [SW-1:0] sum3;
  logic signed [32:0]   us3;
  meta_t                m3;

  logic signed [31+SH:0] ph4;
  logic signed [32+SL:0] pl4;
  logic signed [32:0]    us4;
  meta_t                 m4;

  logic signed [FW-1:0] full5;
  logic signed [FW-1:0] shr5;
  logic signed [CW-1:0] ext5;
  logic signed [35:0]   fs_next;
  logic signed [35:0]   fs5;
  logic signed [32:0]   us5;
  meta_t                m5;

  logic signed [36:0] tot6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[FLUX_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < 6; f++) begin
      ks1[f] <= 33'(signed'(op.kn[f])) + 33'(signed'(op.kc));
      ud1[f] <= 33'(signed'(op.un[f])) - 33'(signed'(op.uc));
    end
    us1 <= 33'(signed'(op.uc)) + 33'(signed'(op.src));
    m1  <= op.meta;
  end

  always_ff @(posedge clk) begin
    for (int f = 0; f < 6; f++) begin
      prod2[f] <= ks1[f] * ud1[f];
    end
    us2 <= us1;
    m2  <= m1;
  end

  always_comb begin
    logic signed [65:0] tmp;
    sum_next = '0;
    for (int f = 0; f < 6; f++) begin
      tmp      = prod2[f] >>> FRAC_BITS;
      sum_next = sum_next + SW'(signed'(tmp[TW-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    sum3 <= sum_next;
    us3  <= us2;
    m3   <= m2;
  end

  always_ff @(posedge clk) begin
    ph4 <= signed'(factor) * signed'(sum3[SW-1:SL]);
    pl4 <= signed'(factor) * signed'({1'b0, sum3[SL-1:0]});
    us4 <= us3;
    m4  <= m3;
  end

  always_comb begin
    full5 = (FW'(ph4) <<< SL) + FW'(pl4);
    shr5  = full5 >>> FRAC_BITS;
    ext5  = CW'(shr5);
    if (ext5 > CW'(LIM)) begin
      fs_next = 36'(LIM);
    end else if (ext5 < -CW'(LIM)) begin
      fs_next = -36'(LIM);
    end else begin
      fs_next = 36'(ext5);
    end
  end

  always_ff @(posedge clk) begin
    fs5 <= fs_next;
    us5 <= us4;
    m5  <= m4;
  end

  assign tot6 = 37'(fs5) + 37'(us5);

  always_ff @(posedge clk) begin
    if (tot6 > MAXV) begin
      res.value <= 32'(MAXV);
    end else if (tot6 < MINV) begin
      res.value <= 32'(MINV);
    end else begin
      res.value <= 32'(tot6);
    end
    res.meta <= m5;
  end

  assign res_valid = v[FLUX_STAGES-1];
  assign busy      = v;

endmodule

// ===== design/vkhs_fifo.sv =====
// Result queue between the arithmetic pipeline and the output stream.
// Depends on vkhs_pkg.
`timescale 1ns / 1ps

module vkhs_fifo import vkhs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  res_t             wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output res_t             rd_data,
  output logic [FIFO_AW:0] count
);

  res_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp, rp;
  logic             pop;

  assign rd_valid = count != '0;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_valid) begin
        wp <= wp + FIFO_AW'(1);
      end
      if (pop) begin
        rp <= rp + FIFO_AW'(1);
      end
      count <= count + (FIFO_AW+1)'(wr_valid) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

// ===== design/vkhs_checker.sv =====
// Port-level checks for the heat stencil top level, bound to it below.
// Depends on variable_kappa_heat_stencil_3d.
`timescale 1ns / 1ps

module vkhs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[37:32] != 6'd0 && m_tdata[43:38] != 6'd0 &&
                 m_tdata[53:44] != 10'd0)
    else $error("result for a boundary point");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:54] == 2'b00)
    else $error("pad bits set");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid && s_tready)
    else $error("not empty and ready after reset");

endmodule

bind variable_kappa_heat_stencil_3d vkhs_checker u_vkhs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
